>>> design/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg: shared types and constants for the best-fit bin packer
// Beat structs for both channels, cell control group, status codes.
// ----------------------------------------------------------------------------
package bfp_pkg;

    localparam int          MAX_BINS_DEF = 512;
    localparam int          WEIGHT_W     = 16;
    localparam logic [15:0] CAP_RESET    = 16'd150;

    // result status codes
    localparam logic [1:0] ST_PLACED     = 2'd0;
    localparam logic [1:0] ST_OVERWEIGHT = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    typedef struct packed {
        logic [15:0] item_weight;
        logic        new_instance;
    } t_in_beat;

    typedef struct packed {
        logic [8:0] bin_index;
        logic [9:0] bins_in_use;
        logic [1:0] status;
    } t_out_beat;

    // control broadcast to every cell of the ring
    typedef struct packed {
        logic                shift;
        logic                wr;
        logic [WEIGHT_W-1:0] wr_val;
    } t_cell_ctl;

endpackage

>>> design/bfp_cell.sv
// ----------------------------------------------------------------------------
// bfp_cell: one bin of the rotating bin store
// Holds one remaining-space word; shifts in from its neighbor or takes an
// update when the write index matches its own slot.
// ----------------------------------------------------------------------------
module bfp_cell
    import bfp_pkg::*;
#(
    parameter int IDX_W = 9,
    parameter int IDX   = 0
) (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  logic [WEIGHT_W-1:0] i_next,
    output logic [WEIGHT_W-1:0] o_space
);

    logic [WEIGHT_W-1:0] r_space;

    // rotate with the ring, or load the one updated bin
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_space <= i_next;
        end else if (i_ctl.wr && (i_wr_idx == IDX_W'(IDX))) begin
            r_space <= i_ctl.wr_val;
        end
    end

    assign o_space = r_space;

endmodule

>>> design/best_fit_bin_packer_core.sv
// ----------------------------------------------------------------------------
// best_fit_bin_packer_core: online best-fit bin packer
// One item is in work at a time: an accepted item beat is searched over one full
//   rotation of the bin ring past the compare unit at its head, then the chosen
//   bin is updated and the result beat is registered; an overweight item skips
//   the search and the update.
// Reset: control, open-bin count and output valid are cleared, capacity is
//   set to 150; the bin store is not cleared, bins are written when opened.
// ----------------------------------------------------------------------------
module best_fit_bin_packer_core
    import bfp_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in_beat      i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_out_beat     o_out_data,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_open, n_open;
    logic [CW-1:0]       r_k, n_k;
    logic [WEIGHT_W-1:0] r_weight, n_weight;
    logic [WEIGHT_W-1:0] r_cap;
    logic                r_found, n_found;
    logic [IW-1:0]       r_best, n_best;
    logic [WEIGHT_W-1:0] r_best_val, n_best_val;
    t_out_beat           r_res, n_res;
    logic                r_out_valid;
    t_out_beat           r_out_data;

    t_cell_ctl           w_ctl;
    logic [IW-1:0]       w_wr_idx;
    logic [WEIGHT_W-1:0] w_space [MAX_BINS];
    logic [WEIGHT_W-1:0] w_head;
    logic                w_hit;
    logic                w_in_acc;
    logic                w_out_free;

    // ring of bin cells, cell i takes from cell i+1, head is cell 0
    for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
        bfp_cell #(
            .IDX_W (IW),
            .IDX   (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_wr_idx (w_wr_idx),
            .i_next   (w_space[(g + 1) % MAX_BINS]),
            .o_space  (w_space[g])
        );
    end

    assign w_head     = w_space[0];
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // head compare: open bin that holds the item and beats the best so far
    assign w_hit = (r_k < r_open) && (w_head >= r_weight) &&
                   (!r_found || (w_head < r_best_val));

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_open     = r_open;
        n_k        = r_k;
        n_weight   = r_weight;
        n_found    = r_found;
        n_best     = r_best;
        n_best_val = r_best_val;
        n_res      = r_res;
        w_ctl      = '0;
        w_wr_idx   = r_best;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_weight = i_in_data.item_weight;
                    n_open   = i_in_data.new_instance ? '0 : r_open;
                    n_k      = '0;
                    n_found  = 1'b0;
                    if (i_in_data.item_weight > r_cap) begin
                        n_res.bin_index   = '0;
                        n_res.bins_in_use = 10'(n_open);
                        n_res.status      = ST_OVERWEIGHT;
                        n_state           = S_DONE;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                w_ctl.shift = 1'b1;
                if (w_hit) begin
                    n_found    = 1'b1;
                    n_best     = IW'(r_k);
                    n_best_val = w_head;
                end
                n_k = r_k + 1'b1;
                if (r_k == CW'(MAX_BINS - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_DONE;
                if (r_found) begin
                    w_ctl.wr          = 1'b1;
                    w_ctl.wr_val      = r_best_val - r_weight;
                    w_wr_idx          = r_best;
                    n_res.bin_index   = 9'(r_best);
                    n_res.bins_in_use = 10'(r_open);
                    n_res.status      = ST_PLACED;
                end else if (r_open >= CW'(MAX_BINS)) begin
                    n_res.bin_index   = '0;
                    n_res.bins_in_use = 10'(r_open);
                    n_res.status      = ST_FULL;
                end else begin
                    w_ctl.wr          = 1'b1;
                    w_ctl.wr_val      = r_cap - r_weight;
                    w_wr_idx          = IW'(r_open);
                    n_open            = r_open + 1'b1;
                    n_res.bin_index   = 9'(r_open);
                    n_res.bins_in_use = 10'(n_open);
                    n_res.status      = ST_PLACED;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open  <= '0;
            r_found <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_found <= n_found;
            r_k     <= n_k;
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        r_weight   <= n_weight;
        r_best     <= n_best;
        r_best_val <= n_best_val;
        r_res      <= n_res;
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> tb/bin_pack_checker.sv
// ----------------------------------------------------------------------------
// bin_pack_checker: placement predictor and result checker for the packer
// Watches the item, result and capacity ports of the best-fit packer. It keeps
// its own copy of the bin store and predicts the placement of every accepted
// item beat. Each accepted result beat is compared field by field with the
// oldest predicted placement.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bin_pack_checker
    import bfp_pkg::*;
#(
    parameter int NUM_BINS = MAX_BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_beat    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_beat   i_out_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    // shadow of the bin store and the capacity register
    logic [15:0] bin_space [NUM_BINS];
    int unsigned bins_open;
    logic [15:0] capacity;

    t_out_beat   expected_placements [$];
    int          mismatches = 0;

    // best-fit placement of one item; updates the shadow store
    function automatic t_out_beat best_fit_place(input t_in_beat beat);
        t_out_beat   res;
        logic [15:0] weight;
        int unsigned best;
        int unsigned i;
        bit          found;
        weight = beat.item_weight;
        res    = '0;
        best   = 0;
        found  = 1'b0;
        if (beat.new_instance)
            bins_open = 0;
        // overweight is judged against the current capacity only
        if (weight > capacity) begin
            res.bins_in_use = bins_open[9:0];
            res.status      = ST_OVERWEIGHT;
            return res;
        end
        // tightest fit, lowest index on a tie
        for (i = 0; i < bins_open; i++) begin
            if (bin_space[i] >= weight && (!found || bin_space[i] < bin_space[best])) begin
                best  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            bin_space[best] = bin_space[best] - weight;
            res.bin_index   = best[8:0];
            res.bins_in_use = bins_open[9:0];
            res.status      = ST_PLACED;
            return res;
        end
        if (bins_open >= NUM_BINS) begin
            res.bins_in_use = bins_open[9:0];
            res.status      = ST_FULL;
            return res;
        end
        // open a fresh bin at the next index
        bin_space[bins_open] = capacity - weight;
        res.bin_index        = bins_open[8:0];
        bins_open++;
        res.bins_in_use      = bins_open[9:0];
        res.status           = ST_PLACED;
        return res;
    endfunction

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            bins_open = 0;
            capacity  = CAP_RESET;
            expected_placements.delete();
        end else begin
            if (i_cfg_we)
                capacity = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                expected_placements = {expected_placements, best_fit_place(i_in_data)};
            if (i_out_valid && !i_out_stall) begin
                if (expected_placements.size() == 0) begin
                    $error("result beat with no item pending: bin_index %0d bins_in_use %0d %s",
                           i_out_data.bin_index, i_out_data.bins_in_use,
                           $sformatf("status %0d", i_out_data.status));
                    mismatches++;
                end else begin
                    want = expected_placements.pop_front();
                    if (i_out_data.bin_index !== want.bin_index) begin
                        $error("bin_index: expected %0d, actual %0d",
                               want.bin_index, i_out_data.bin_index);
                        mismatches++;
                    end
                    if (i_out_data.bins_in_use !== want.bins_in_use) begin
                        $error("bins_in_use: expected %0d, actual %0d",
                               want.bins_in_use, i_out_data.bins_in_use);
                        mismatches++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_out_data.status);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_placements.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the best-fit bin packer
// Drives item beats in random bursts, stalls the result channel on a changing
// pattern with one long hold-off, and rewrites the bin capacity between
// phases while the block is idle. Checking is done by bin_pack_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import bfp_pkg::*;

    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int DRAIN_CYCLES = MAX_BINS_DEF + 16;
    localparam int HOLD_START   = 20_000;
    localparam int HOLD_LEN     = 3_000;

    typedef enum int {W_MIXED, W_WIDE, W_UNIT} t_weight_mix;
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_stall_mode;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_beat    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_beat   out_data;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          burst_left;
    int          cycle_count = 0;

    best_fit_bin_packer_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bin_pack_checker #(.NUM_BINS(MAX_BINS_DEF)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result-side stall pattern, with one long hold-off
    always @(posedge clk) begin
        static int          rx_cycle   = 0;
        static int          mode_left  = 0;
        static int          hold_left  = 0;
        static t_stall_mode stall_mode = RX_OPEN;
        rx_cycle++;
        if (rx_cycle == HOLD_START)
            hold_left = HOLD_LEN;
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(200, 3000);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                RX_OPEN:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:  out_stall <= ((rx_cycle % 16) < 5);
            endcase
        end
    end

    // one item beat; waits for acceptance, then maybe a gap between bursts
    task automatic send_beat(input logic [15:0] weight, input logic fresh);
        t_in_beat beat;
        beat.item_weight  = weight;
        beat.new_instance = fresh;
        in_data  <= beat;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            // mostly short gaps, now and then one that spans a whole item
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 600)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    // capacity write once every result is back
    task automatic set_capacity(input logic [15:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] pick_weight(input logic [15:0] cap, input t_weight_mix mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mix)
            W_UNIT: begin
                if (roll < 3)
                    return 16'd0;
                if (roll < 6)
                    return 16'd2;
                return 16'd1;
            end
            W_WIDE: begin
                if (roll < 10)
                    return 16'hFFFF;
                return 16'($urandom);
            end
            default: begin
                if (roll < 4)
                    return 16'($urandom);
                if (roll < 7 && cap != 16'hFFFF)
                    return cap + 16'd1;
                if (roll < 9)
                    return 16'd0;
                if (roll < 12)
                    return cap;
                if (roll < 50)
                    return 16'($urandom_range(1, (cap >> 2) + 1));
                return 16'($urandom_range(1, cap));
            end
        endcase
    endfunction

    // one random phase; every phase opens with a fresh instance
    task automatic run_phase(input int count, input logic [15:0] cap,
                             input t_weight_mix mix, input int fresh_odds);
        logic fresh;
        set_capacity(cap);
        for (int n = 0; n < count; n++) begin
            fresh = (n == 0) || (fresh_odds > 0 && $urandom_range(1, fresh_odds) == 1);
            send_beat(pick_weight(cap, mix), fresh);
        end
    endtask

    initial begin
        burst_left = $urandom_range(1, 12);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset capacity, overweight, zero weight, best fit, tie
        send_beat(16'd150,   1'b1);
        send_beat(16'd151,   1'b0);
        send_beat(16'hFFFF,  1'b0);
        send_beat(16'd0,     1'b0);
        send_beat(16'd1,     1'b0);
        send_beat(16'd100,   1'b0);
        send_beat(16'd50,    1'b0);
        send_beat(16'd49,    1'b0);
        send_beat(16'd100,   1'b1);
        send_beat(16'd100,   1'b0);
        send_beat(16'd20,    1'b0);
        send_beat(16'd30,    1'b0);

        // widest capacity and weights
        set_capacity(16'hFFFF);
        send_beat(16'hFFFF,  1'b0);
        send_beat(16'd1,     1'b0);
        send_beat(16'd32768, 1'b0);
        send_beat(16'd0,     1'b0);

        // capacity lowered under an old roomy bin: overweight still wins
        set_capacity(16'd100);
        send_beat(16'd200,   1'b0);
        send_beat(16'd50,    1'b0);

        // zero capacity still opens bins with no room
        set_capacity(16'd0);
        send_beat(16'd0,     1'b1);
        send_beat(16'd0,     1'b0);
        send_beat(16'd1,     1'b0);

        // random phases; unit capacity runs the store full
        run_phase(300, CAP_RESET, W_MIXED, 40);
        run_phase(180, 16'hFFFF, W_WIDE, 30);
        run_phase(580, 16'd1, W_UNIT, 0);
        run_phase(90, 16'($urandom_range(200, 5000)), W_MIXED, 25);

        // drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
